// File: src/itew_pkg.sv
// ----------------------------------------------------------------------------
// itew_pkg
// Shared types and token codes for the integer to English word token block.
// ----------------------------------------------------------------------------
package itew_pkg;

    localparam int NUM_W      = 31;
    localparam int WORD_W     = 5;
    localparam int BCD_DIGITS = 12;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int GROUP_W    = 12;
    localparam int SLOTS      = 20;
    localparam int CNT_W      = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BCD_W-1:0]  bcd_t;
    typedef logic [SLOTS-1:0]  mask_t;
    typedef logic [2:0]        sub_t;

    localparam word_t TOK_ZERO     = 5'd0;
    localparam word_t TOK_TEN      = 5'd10;
    localparam word_t TOK_TWENTY   = 5'd20;
    localparam word_t TOK_HUNDRED  = 5'd28;
    localparam word_t TOK_THOUSAND = 5'd29;
    localparam word_t TOK_MILLION  = 5'd30;
    localparam word_t TOK_BILLION  = 5'd31;

    // position of a word inside one three-digit group
    localparam sub_t SUB_HDIGIT  = 3'd0;
    localparam sub_t SUB_HUNDRED = 3'd1;
    localparam sub_t SUB_TENS    = 3'd2;
    localparam sub_t SUB_UNITS   = 3'd3;
    localparam sub_t SUB_SCALE   = 3'd4;

    localparam logic [1:0] GRP_BILLION  = 2'd0;
    localparam logic [1:0] GRP_MILLION  = 2'd1;
    localparam logic [1:0] GRP_THOUSAND = 2'd2;
    localparam logic [1:0] GRP_UNITS    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

// File: src/integer_to_english_word_tokens.sv
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens
// Names a 31-bit unsigned integer as a run of English word tokens.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request per number, s_tdata[30:0] = number.
//   m_* channel returns the word tokens most significant first, one per
//   transfer, m_tdata[4:0] = word, m_tlast set on the final token.
//   The number is first turned into twelve decimal digits by a shift-and-add-3
//   converter, one input bit per cycle. ST_PREP then builds the map of which
//   of the 20 word slots (four groups of five) give a token. The sequencer
//   walks the slots one per cycle, held on a token's slot while the output
//   register cannot take it, up to the slot of the final token, at most 19
//   slots.
//   s_tready is high only while no number is in work; it rises again in the
//   cycle after the final token has been placed in the output register, so
//   the next number can start while that token still waits to be taken.
//   A stall on m_tready holds the sequencer on its current slot; tokens are
//   never dropped or repeated.
//   Reset (rst_n low) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [30:0] number, [31] zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [4:0] word, [7:5] zero fill
    output logic        m_tlast     // last_word
);
    import itew_pkg::*;

    state_t                 state_reg, state_next;
    logic [NUM_W-1:0]       bin_reg, bin_next;
    bcd_t                   bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    mask_t                  mask_reg, mask_next;
    logic                   zero_reg, zero_next;
    sub_t                   sub_reg, sub_next;
    logic [1:0]             grp_reg, grp_next;
    logic                   m_valid_reg, m_valid_next;
    word_t                  m_word_reg, m_word_next;
    logic                   m_last_reg, m_last_next;

    logic                   emit_now;
    logic                   last_now;
    logic                   can_load;
    word_t                  slot_word;
    logic [3:0]             dig_h, dig_t, dig_u;

    // one shift-and-add-3 step over all digits
    function automatic bcd_t dabble(input bcd_t b, input logic bit_in);
        bcd_t a;
        a = b;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (a[4*i +: 4] >= 4'd5) begin
                a[4*i +: 4] = a[4*i +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    // which slots give a word, first slot of the billion group in the top bit
    function automatic mask_t slot_mask(input bcd_t b);
        mask_t      m;
        logic [3:0] h, t, u;
        logic       hn, rn;
        m = '0;
        for (int k = 0; k < 4; k++) begin
            h  = b[BCD_W-1-GROUP_W*k -: 4];
            t  = b[BCD_W-5-GROUP_W*k -: 4];
            u  = b[BCD_W-9-GROUP_W*k -: 4];
            hn = (h != 4'd0);
            rn = (t != 4'd0) || (u != 4'd0);
            m[SLOTS-1-5*k] = hn;
            m[SLOTS-2-5*k] = hn;
            m[SLOTS-3-5*k] = rn;
            m[SLOTS-4-5*k] = (t >= 4'd2) && (u != 4'd0);
            m[SLOTS-5-5*k] = (k != 3) && (hn || rn);
        end
        return m;
    endfunction

    // every digit of the converter stays decimal
    function automatic logic bcd_ok(input bcd_t b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (b[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign dig_h = bcd_reg[BCD_W-1 -: 4];
    assign dig_t = bcd_reg[BCD_W-5 -: 4];
    assign dig_u = bcd_reg[BCD_W-9 -: 4];

    always_comb
    begin
        case (sub_reg)
            SUB_HDIGIT:  slot_word = {1'b0, dig_h};
            SUB_HUNDRED: slot_word = TOK_HUNDRED;
            SUB_TENS:
            begin
                if (dig_t < 4'd2) begin
                    slot_word = dig_t[0] ? ({1'b0, dig_u} + TOK_TEN) : {1'b0, dig_u};
                end else begin
                    slot_word = TOK_TWENTY + {1'b0, dig_t} - 5'd2;
                end
            end
            SUB_UNITS:   slot_word = {1'b0, dig_u};
            SUB_SCALE:
            begin
                case (grp_reg)
                    GRP_BILLION: slot_word = TOK_BILLION;
                    GRP_MILLION: slot_word = TOK_MILLION;
                    default:     slot_word = TOK_THOUSAND;
                endcase
            end
            default:     slot_word = TOK_ZERO;
        endcase
    end

    assign emit_now = zero_reg || mask_reg[SLOTS-1];
    assign last_now = zero_reg || (mask_reg[SLOTS-2:0] == '0);
    assign can_load = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        mask_next    = mask_reg;
        zero_next    = zero_reg;
        sub_next     = sub_reg;
        grp_next     = grp_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_word_next  = m_word_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    bin_next   = s_tdata[NUM_W-1:0];
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = dabble(bcd_reg, bin_reg[NUM_W-1]);
                bin_next = {bin_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                mask_next  = slot_mask(bcd_reg);
                zero_next  = (slot_mask(bcd_reg) == '0);
                sub_next   = SUB_HDIGIT;
                grp_next   = GRP_BILLION;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!emit_now || can_load) begin
                    if (emit_now) begin
                        m_valid_next = 1'b1;
                        m_word_next  = zero_reg ? TOK_ZERO : slot_word;
                        m_last_next  = last_now;
                    end
                    if (emit_now && last_now) begin
                        mask_next  = '0;
                        zero_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        mask_next = {mask_reg[SLOTS-2:0], 1'b0};
                        if (sub_reg == SUB_SCALE) begin
                            sub_next = SUB_HDIGIT;
                            grp_next = grp_reg + 1'b1;
                            bcd_next = {bcd_reg[BCD_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
                        end else begin
                            sub_next = sub_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            mask_reg    <= '0;
            zero_reg    <= 1'b0;
            sub_reg     <= SUB_HDIGIT;
            grp_reg     <= GRP_BILLION;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            mask_reg    <= mask_next;
            zero_reg    <= zero_next;
            sub_reg     <= sub_next;
            grp_reg     <= grp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        m_word_reg <= m_word_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_word_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_CONV)
        else $error("accepted request did not start conversion");

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT || state_reg == ST_PREP |-> bcd_ok(bcd_reg))
        else $error("converter digit above nine");

    a_zero_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4:0] == TOK_ZERO |-> m_tlast)
        else $error("zero token not flagged as last");

    a_idle_mask_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> mask_reg == '0 && !zero_reg)
        else $error("idle with word slots still pending");
`endif

endmodule

// File: dv/tb_integer_to_english_word_tokens.sv
// ----------------------------------------------------------------------------
// tb_integer_to_english_word_tokens
// Self-checking bench for the integer to English word token block.
// ----------------------------------------------------------------------------
// Numbers are queued in an initial block and sent as requests by a clocked
// driver that works in bursts with gaps. A clocked monitor spells every
// accepted number into a queue of expected tokens. Each token that leaves
// the block is checked against that queue, word and last flag. The receiver
// stalls on changing patterns and holds off once for a long stretch so that
// the block backs up onto its input. Stimulus opens with directed numbers:
// zero, teens, round tens and hundreds, scale boundaries, the longest
// spelling and the largest value. Random numbers follow, about four in ten of
// them built group by group.
// ----------------------------------------------------------------------------
module tb_integer_to_english_word_tokens;

    import itew_pkg::*;

    typedef logic [NUM_W-1:0] num_t;

    typedef struct packed {
        word_t word;
        logic  last;
    } token_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_RARE
    } rx_mode_t;

    localparam int N_RANDOM    = 340;
    localparam int HOLD_AFTER  = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 120;
    localparam int IDLE_LIMIT  = 4000;
    localparam longint unsigned NUM_MAX = 64'd2147483647;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [30:0] number, [31] zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [4:0] word, [7:5] zero fill
    logic        m_tlast;

    num_t   pending_numbers[$];
    token_t expected_tokens[$];

    logic     req_taken = 1'b0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;
    int       mode_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    logic [7:0] ready_pattern = 8'hA5;

    int numbers_taken  = 0;
    int tokens_checked = 0;
    int longest_run    = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;

    integer_to_english_word_tokens dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // spells one number into the expected token queue
    function automatic void spell_number(input num_t n);
        word_t           words[$];
        longint unsigned scale_div[4];
        word_t           scale_word[4];
        longint unsigned grp;
        longint unsigned rest;
        longint unsigned hund;
        token_t          tok;

        scale_div[0]  = 1;
        scale_div[1]  = 1000;
        scale_div[2]  = 1000000;
        scale_div[3]  = 1000000000;
        scale_word[0] = TOK_ZERO;
        scale_word[1] = TOK_THOUSAND;
        scale_word[2] = TOK_MILLION;
        scale_word[3] = TOK_BILLION;

        if (n == '0)
            words.push_back(TOK_ZERO);
        for (int s = 3; s >= 0; s--)
        begin
            grp = (longint'(n) / scale_div[s]) % 1000;
            if (grp == 0)
                continue;
            hund = grp / 100;
            rest = grp % 100;
            if (hund != 0)
            begin
                words.push_back(word_t'(hund));
                words.push_back(TOK_HUNDRED);
            end
            if (rest != 0 && rest < 20)
                words.push_back(word_t'(rest));
            else if (rest >= 20)
            begin
                words.push_back(TOK_TWENTY + word_t'(rest / 10 - 2));
                if (rest % 10 != 0)
                    words.push_back(word_t'(rest % 10));
            end
            if (s != 0)
                words.push_back(scale_word[s]);
        end

        foreach (words[i])
        begin
            tok.word = words[i];
            tok.last = (i == words.size() - 1);
            expected_tokens.push_back(tok);
        end
        if (words.size() > longest_run)
            longest_run = words.size();
    endfunction

    function automatic longint unsigned pick_group();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(1, 19);
            2: return 10 * $urandom_range(2, 9);
            3: return 100 * $urandom_range(1, 9);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    function automatic num_t pick_number();
        longint unsigned v;
        longint unsigned p;
        int              k;

        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                v = longint'($urandom_range(0, 2)) * 1000000000
                    + pick_group() * 1000000 + pick_group() * 1000 + pick_group();
                if (v > NUM_MAX)
                    v = v - 64'd1000000000;
            end
            4, 5: v = $urandom & 32'h7FFF_FFFF;
            6, 7: v = $urandom & ((32'd1 << $urandom_range(1, 31)) - 1);
            8: v = $urandom_range(0, 999);
            default:
            begin
                k = $urandom_range(0, 9);
                p = 1;
                repeat (k) p = p * 10;
                v = p * ((k == 9) ? $urandom_range(1, 2) : $urandom_range(1, 9));
            end
        endcase
        return num_t'(v);
    endfunction

    // sender: bursts of requests with random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (s_tvalid && !req_taken)
        begin
            s_tvalid <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_numbers.size() > 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, pending_numbers.pop_front()};
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 30);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            s_tvalid <= 1'b0;
    end

    // receiver: changing stall patterns, plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && numbers_taken >= HOLD_AFTER)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode       <= rx_mode_t'($urandom_range(0, 3));
                mode_left     <= $urandom_range(50, 400);
                ready_pattern <= 8'($urandom) | 8'h01;
            end
            else
            begin
                mode_left <= mode_left - 1;
                if (rx_mode == RX_PATTERN)
                    ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
            end
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_tready <= ready_pattern[0];
                default:    m_tready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // monitor: predicts on accepted requests, checks outgoing tokens
    always @(posedge clk)
    begin
        token_t want;

        req_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                spell_number(s_tdata[NUM_W-1:0]);
                numbers_taken <= numbers_taken + 1;
            end
            if (m_tvalid && m_tready)
            begin
                tokens_checked <= tokens_checked + 1;
                if (expected_tokens.size() == 0)
                begin
                    $error("token with none expected: word %0d last %0b",
                           m_tdata[WORD_W-1:0], m_tlast);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (m_tdata[WORD_W-1:0] !== want.word)
                    begin
                        $error("word mismatch: expected %0d, actual %0d",
                               want.word, m_tdata[WORD_W-1:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_word mismatch: expected %0b, actual %0b",
                               want.last, m_tlast);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        num_t directed[$];

        directed = '{
            31'd0, 31'd1, 31'd9, 31'd10, 31'd13, 31'd19, 31'd20, 31'd21,
            31'd90, 31'd99, 31'd100, 31'd101, 31'd115, 31'd999, 31'd1000,
            31'd1010, 31'd100000, 31'd1000001, 31'd12000345, 31'd1000000000,
            31'd1777777777, 31'd1073741824, 31'd2000000000, 31'd2147483647
        };
        foreach (directed[i])
            pending_numbers.push_back(directed[i]);
        repeat (N_RANDOM) pending_numbers.push_back(pick_number());

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_numbers.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_tokens.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("summary: %0d numbers spelt, %0d tokens checked, longest run %0d tokens",
                 numbers_taken, tokens_checked, longest_run);
        $display("summary: receiver hold-off of %0d cycles applied after %0d numbers",
                 HOLD_CYCLES, HOLD_AFTER);
        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
